/* design/bmad_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and address maps for the banked memory access decoder
// no dependencies; used by bmad_decode and banked_memory_access_decoder

package bmad_pkg;

	localparam int unsigned BANK_BYTES = 65536;
	localparam int unsigned ADDR_W     = $clog2(BANK_BYTES);
	localparam int unsigned NUM_BANKS  = 4;
	localparam int unsigned BYTE_W     = 8;

	localparam logic [BYTE_W-1:0] BYTE_FF       = 8'hFF;
	localparam logic [ADDR_W-1:0] ROM_TOP       = 16'h6000;
	localparam logic [ADDR_W-1:0] DISK_ROM_BASE = 16'hE000;
	localparam logic [ADDR_W-1:0] FLAT_WR_BASE  = 16'h4000;

	// request kinds; code 3 is unused and does nothing
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_LOAD  = 2'd2
	} bmad_kind_t;

	typedef enum logic [1:0] {
		MODE_FLAT = 2'd0,
		MODE_48K  = 2'd1,
		MODE_96K  = 2'd2,
		MODE_128K = 2'd3
	} bmad_mode_t;

	// bank index, also the load target code
	typedef enum logic [1:0] {
		BANK_ROM   = 2'd0,
		BANK_USER  = 2'd1,
		BANK_VIDEO = 2'd2,
		BANK_ALT   = 2'd3
	} bmad_bank_t;

	// bank that answers a read
	typedef enum logic [2:0] {
		SRC_NONE  = 3'd0,
		SRC_ROM   = 3'd1,
		SRC_USER  = 3'd2,
		SRC_VIDEO = 3'd3,
		SRC_ALT   = 3'd4
	} bmad_src_t;

	// decoded request: per-bank write enables and addresses, read source
	typedef struct packed {
		logic [NUM_BANKS-1:0]             we;
		logic [NUM_BANKS-1:0][ADDR_W-1:0] addr;
		bmad_src_t                        src;
	} bmad_acc_t;

	// 8K region remap of the 48K user mirror
	function automatic logic [2:0] user_region(input logic [2:0] r);
		logic [2:0] o;
		unique case (r)
			3'd0, 3'd1, 3'd4, 3'd5: o = 3'd4;
			default:                o = 3'd3;
		endcase
		return o;
	endfunction

	// 8K region remap of the video planes
	function automatic logic [2:0] video_region(input logic [2:0] r);
		logic [2:0] o;
		unique case (r)
			3'd0, 3'd1, 3'd4, 3'd5: o = 3'd5;
			default:                o = 3'd6;
		endcase
		return o;
	endfunction

endpackage

/* design/bmad_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module bmad_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/bmad_decode.sv */
`timescale 1ns / 1ps
// address decode: bank addresses, write enables and read source of a request
// depends on bmad_pkg

module bmad_decode (
	input  bmad_pkg::bmad_kind_t            kind,
	input  logic [bmad_pkg::ADDR_W-1:0]     address,
	input  logic [1:0]                      bank_number,
	input  logic [7:0]                      bank_select,
	input  logic [7:0]                      video_select,
	input  logic                            disk_rom_off,
	input  bmad_pkg::bmad_mode_t            mode,
	input  logic                            disk_present,
	output bmad_pkg::bmad_acc_t             acc
);

	logic                          rom_ok;
	logic [bmad_pkg::ADDR_W-1:0]   user_addr;
	logic [bmad_pkg::ADDR_W-1:0]   vid_addr;
	logic [bmad_pkg::ADDR_W-1:0]   vid_map;
	logic                          is_load;

	assign is_load = (kind == bmad_pkg::KIND_LOAD);

	// rom window: low 24K, plus disk rom at the top when present and enabled
	assign rom_ok = (address < bmad_pkg::ROM_TOP) ||
		(disk_present && (address >= bmad_pkg::DISK_ROM_BASE) && !disk_rom_off);

	assign vid_map = {bmad_pkg::video_region(address[15:13]), address[12:0]};

	always_comb begin
		user_addr = address;
		if ((mode == bmad_pkg::MODE_48K) && !is_load) begin
			user_addr = {bmad_pkg::user_region(address[15:13]), address[12:0]};
		end
		vid_addr = vid_map;
		if ((mode == bmad_pkg::MODE_128K) || is_load) begin
			vid_addr = address;
		end
	end

	always_comb begin
		acc.we  = '0;
		acc.src = bmad_pkg::SRC_NONE;
		acc.addr[bmad_pkg::BANK_ROM]   = address;
		acc.addr[bmad_pkg::BANK_USER]  = user_addr;
		acc.addr[bmad_pkg::BANK_VIDEO] = vid_addr;
		acc.addr[bmad_pkg::BANK_ALT]   = is_load ? address : vid_map;

		unique case (kind)
			bmad_pkg::KIND_READ: begin
				unique case (mode)
					bmad_pkg::MODE_FLAT: begin
						acc.src = bmad_pkg::SRC_ROM;
					end
					bmad_pkg::MODE_128K: begin
						priority if (!bank_select[3] && rom_ok) begin
							acc.src = bmad_pkg::SRC_ROM;
						end else if (bank_select[1]) begin
							acc.src = bmad_pkg::SRC_VIDEO;
						end else if (!bank_select[2]) begin
							acc.src = bmad_pkg::SRC_USER;
						end else begin
							acc.src = bmad_pkg::SRC_NONE;
						end
					end
					default: begin
						priority if (!bank_select[4] && rom_ok) begin
							acc.src = bmad_pkg::SRC_ROM;
						end else if (!bank_select[5]) begin
							acc.src = bmad_pkg::SRC_USER;
						end else if (bank_select[6] && !video_select[2]) begin
							acc.src = bmad_pkg::SRC_VIDEO;
						end else if (bank_select[6] && !video_select[3]) begin
							acc.src = bmad_pkg::SRC_ALT;
						end else begin
							acc.src = bmad_pkg::SRC_NONE;
						end
					end
				endcase
			end
			bmad_pkg::KIND_WRITE: begin
				unique case (mode)
					bmad_pkg::MODE_FLAT: begin
						acc.we[bmad_pkg::BANK_ROM] = (address >= bmad_pkg::FLAT_WR_BASE);
					end
					bmad_pkg::MODE_128K: begin
						acc.we[bmad_pkg::BANK_USER]  = !bank_select[7];
						acc.we[bmad_pkg::BANK_VIDEO] = bank_select[6];
					end
					default: begin
						acc.we[bmad_pkg::BANK_USER]  = !bank_select[0];
						acc.we[bmad_pkg::BANK_VIDEO] = bank_select[1] && !video_select[2];
						acc.we[bmad_pkg::BANK_ALT]   = bank_select[2] && !video_select[3];
					end
				endcase
			end
			bmad_pkg::KIND_LOAD: begin
				acc.we[bank_number] = 1'b1;
			end
			default: begin
				acc.we = '0;
			end
		endcase
	end

endmodule

/* design/banked_memory_access_decoder.sv */
`timescale 1ns / 1ps
// top level of the banked memory access decoder: four bank rams, clear sweep,
// read pipeline and result register; depends on bmad_pkg, bmad_ram, bmad_decode

// Banked memory of a small 8-bit home computer seen from the cpu bus. Each
// request is a cpu read, a cpu write or a direct load into a named bank; every
// request gives exactly one result (read_data, mapped), 0xFF/0 for anything
// but a read that found a bank. The four 64K banks (rom, user ram, video,
// video alternate) each live in their own ram with a registered read. After
// reset the block sweeps all four rams to 0xFF, one address per cycle, and
// in_stall stays high for the whole sweep; machine_mode writes are taken
// during that time. After the sweep one request is accepted every cycle
// while the result side does not stall: the decode and ram access happen at
// acceptance, the bank select happens in stage 1 and the result register
// loads when stage 1 moves on, which waits while the result register is full
// and out_stall is high. Writes land in the ram at acceptance, so a read
// accepted in the next cycle already sees the new byte. The rate is one
// request per cycle, set by the single ram access per bank per request.
// machine_mode may only be changed while the block is idle.

module banked_memory_access_decoder (
	input  logic       clk,
	input  logic       arst_n,
	// machine mode register
	input  logic       mode_we,
	input  logic [1:0] mode_wdata,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [15:0] address,
	input  logic [7:0] write_data,
	input  logic [1:0] bank_number,
	input  logic [7:0] bank_select,
	input  logic [7:0] video_select,
	input  logic       disk_rom_off,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       mapped
);

	localparam int unsigned AW = bmad_pkg::ADDR_W;
	localparam int unsigned NB = bmad_pkg::NUM_BANKS;
	localparam int unsigned BW = bmad_pkg::BYTE_W;

	// configuration and bank state
	bmad_pkg::bmad_mode_t mode_q;
	logic                 disk_present_q;

	// clear sweep
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// pipeline
	bmad_pkg::bmad_acc_t acc;
	logic                accept;
	logic                valid_s1;
	bmad_pkg::bmad_src_t src_s1;
	logic                s1_move;
	logic                out_valid_q;
	logic [BW-1:0]       read_data_q;
	logic                mapped_q;
	logic [BW-1:0]       sel_data;

	// ram ports
	logic [NB-1:0]             ram_we;
	logic [NB-1:0][AW-1:0]     ram_waddr;
	logic [BW-1:0]             ram_wdata;
	logic [NB-1:0][BW-1:0]     ram_rdata;

	// s1 advances when the result register is empty or being taken
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !s1_move);
	assign accept   = in_valid && !in_stall;

	bmad_decode u_decode (
		.kind         (bmad_pkg::bmad_kind_t'(kind)),
		.address      (address),
		.bank_number  (bank_number),
		.bank_select  (bank_select),
		.video_select (video_select),
		.disk_rom_off (disk_rom_off),
		.mode         (mode_q),
		.disk_present (disk_present_q),
		.acc          (acc)
	);

	// sweep writes 0xFF everywhere, otherwise the request writes
	assign ram_wdata = clearing_q ? bmad_pkg::BYTE_FF : write_data;

	for (genvar b = 0; b < NB; b++) begin : g_bank
		assign ram_we[b]    = clearing_q || (accept && acc.we[b]);
		assign ram_waddr[b] = clearing_q ? clr_addr_q : acc.addr[b];

		bmad_ram #(
			.WIDTH (BW),
			.DEPTH (bmad_pkg::BANK_BYTES)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[b]),
			.waddr (ram_waddr[b]),
			.wdata (ram_wdata),
			.re    (accept),
			.raddr (acc.addr[b]),
			.rdata (ram_rdata[b])
		);
	end

	// machine mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bmad_pkg::MODE_48K;
		end else if (mode_we) begin
			mode_q <= bmad_pkg::bmad_mode_t'(mode_wdata);
		end
	end

	// disk rom presence follows rom byte 0xE000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_present_q <= 1'b0;
		end else if (accept && acc.we[bmad_pkg::BANK_ROM] &&
				(acc.addr[bmad_pkg::BANK_ROM] == bmad_pkg::DISK_ROM_BASE)) begin
			disk_present_q <= (write_data != bmad_pkg::BYTE_FF);
		end
	end

	// clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == {AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// stage 1: ram read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1 <= acc.src;
		end
	end

	// pick the answering bank
	always_comb begin
		unique case (src_s1)
			bmad_pkg::SRC_ROM:   sel_data = ram_rdata[bmad_pkg::BANK_ROM];
			bmad_pkg::SRC_USER:  sel_data = ram_rdata[bmad_pkg::BANK_USER];
			bmad_pkg::SRC_VIDEO: sel_data = ram_rdata[bmad_pkg::BANK_VIDEO];
			bmad_pkg::SRC_ALT:   sel_data = ram_rdata[bmad_pkg::BANK_ALT];
			default:             sel_data = bmad_pkg::BYTE_FF;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_data_q <= sel_data;
			mapped_q    <= (src_s1 != bmad_pkg::SRC_NONE);
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign mapped    = mapped_q;

	// an unmapped result always carries 0xFF
	a_unmapped_ff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !mapped_q |-> read_data_q == bmad_pkg::BYTE_FF)
		else $error("unmapped result without 0xFF");

	// the clear sweep runs once after reset only
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clear sweep restarted");

	// a stuck stage 1 keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1 && $stable(src_s1))
		else $error("stage 1 lost a request");

	// no request is taken while the rams are being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !accept && !valid_s1)
		else $error("request accepted during clear sweep");

	// disk rom presence tracks the byte written at 0xE000
	a_disk_present: assert property (@(posedge clk) disable iff (!arst_n)
		accept && acc.we[bmad_pkg::BANK_ROM] &&
		acc.addr[bmad_pkg::BANK_ROM] == bmad_pkg::DISK_ROM_BASE
		|=> disk_present_q == ($past(write_data) != bmad_pkg::BYTE_FF))
		else $error("disk rom presence not updated");

endmodule

/* sim/bmad_access_check.sv */
`timescale 1ns / 1ps
// request/result checker for the banked memory access decoder: keeps its own copy of the
// four banks and the machine mode, predicts each result and compares; depends on bmad_pkg

module bmad_access_check
	import bmad_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic [1:0] mode_wdata,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] kind,
	input  logic [15:0] address,
	input  logic [7:0] write_data,
	input  logic [1:0] bank_number,
	input  logic [7:0] bank_select,
	input  logic [7:0] video_select,
	input  logic       disk_rom_off,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_data,
	input  logic       mapped,
	output int         errors,
	output int         pending,
	output int         mapped_reads
);

	// bank latch bits, 48K and 96K modes
	localparam int BS_USER_WR_OFF = 0;
	localparam int BS_VID_WR      = 1;
	localparam int BS_ALT_WR      = 2;
	localparam int BS_ROM_RD_OFF  = 4;
	localparam int BS_USER_RD_OFF = 5;
	localparam int BS_VID_RD      = 6;
	// bank latch bits, 128K mode
	localparam int BS3_VID_RD      = 1;
	localparam int BS3_USER_RD_OFF = 2;
	localparam int BS3_ROM_RD_OFF  = 3;
	localparam int BS3_VID_WR      = 6;
	localparam int BS3_USER_WR_OFF = 7;
	// video latch bits
	localparam int VS_VID_OFF = 2;
	localparam int VS_ALT_OFF = 3;

	typedef struct packed {
		logic [7:0] data;
		logic       hit;
	} bus_result_t;

	logic [7:0]  rom_mem   [BANK_BYTES];
	logic [7:0]  user_mem  [BANK_BYTES];
	logic [7:0]  video_mem [BANK_BYTES];
	logic [7:0]  alt_mem   [BANK_BYTES];
	logic        disk_present;
	bmad_mode_t  mode_q;
	bus_result_t result_q [$];
	bus_result_t predicted;
	bus_result_t oldest;
	int          results_seen;

	assign pending = result_q.size();

	function automatic logic [15:0] user_mirror(input logic [15:0] a);
		if (a < 16'h2000) return a + 16'h8000;
		if (a < 16'h4000) return a + 16'h6000;
		if (a < 16'h6000) return a + 16'h2000;
		if (a < 16'hA000) return a;
		if (a < 16'hC000) return a - 16'h2000;
		if (a < 16'hE000) return a - 16'h6000;
		return a - 16'h8000;
	endfunction

	function automatic logic [15:0] video_mirror(input logic [15:0] a);
		if (a < 16'h2000) return a + 16'hA000;
		if (a < 16'h6000) return a + 16'h8000;
		if (a < 16'h8000) return a + 16'h6000;
		if (a < 16'hA000) return a + 16'h2000;
		if (a < 16'hE000) return a;
		return a - 16'h2000;
	endfunction

	function automatic logic rom_answers(input logic [15:0] a, input logic off);
		return (a < ROM_TOP) || (disk_present && a >= DISK_ROM_BASE && !off);
	endfunction

	task automatic rom_store(input logic [15:0] a, input logic [7:0] v);
		rom_mem[a] = v;
		if (a == DISK_ROM_BASE)
			disk_present = (v != BYTE_FF);
	endtask

	task automatic apply_request(output bus_result_t res);
		logic [15:0] ua;
		logic [15:0] va;
		ua = (mode_q == MODE_96K) ? address : user_mirror(address);
		va = video_mirror(address);
		res.data = BYTE_FF;
		res.hit = 1'b0;
		case (kind)
			KIND_READ: begin
				case (mode_q)
					MODE_FLAT: begin
						res = '{rom_mem[address], 1'b1};
					end
					MODE_128K: begin
						if (!bank_select[BS3_ROM_RD_OFF] && rom_answers(address, disk_rom_off))
							res = '{rom_mem[address], 1'b1};
						else if (bank_select[BS3_VID_RD])
							res = '{video_mem[address], 1'b1};
						else if (!bank_select[BS3_USER_RD_OFF])
							res = '{user_mem[address], 1'b1};
					end
					default: begin
						if (!bank_select[BS_ROM_RD_OFF] && rom_answers(address, disk_rom_off))
							res = '{rom_mem[address], 1'b1};
						else if (!bank_select[BS_USER_RD_OFF])
							res = '{user_mem[ua], 1'b1};
						else if (bank_select[BS_VID_RD]) begin
							if (!video_select[VS_VID_OFF])
								res = '{video_mem[va], 1'b1};
							else if (!video_select[VS_ALT_OFF])
								res = '{alt_mem[va], 1'b1};
						end
					end
				endcase
			end
			KIND_WRITE: begin
				case (mode_q)
					MODE_FLAT: begin
						if (address >= FLAT_WR_BASE)
							rom_store(address, write_data);
					end
					MODE_128K: begin
						if (!bank_select[BS3_USER_WR_OFF])
							user_mem[address] = write_data;
						if (bank_select[BS3_VID_WR])
							video_mem[address] = write_data;
					end
					default: begin
						if (!bank_select[BS_USER_WR_OFF])
							user_mem[ua] = write_data;
						if (bank_select[BS_VID_WR] && !video_select[VS_VID_OFF])
							video_mem[va] = write_data;
						if (bank_select[BS_ALT_WR] && !video_select[VS_ALT_OFF])
							alt_mem[va] = write_data;
					end
				endcase
			end
			KIND_LOAD: begin
				case (bank_number)
					BANK_ROM:   rom_store(address, write_data);
					BANK_USER:  user_mem[address] = write_data;
					BANK_VIDEO: video_mem[address] = write_data;
					default:    alt_mem[address] = write_data;
				endcase
			end
			default: ;
		endcase
	endtask

	task automatic flag_error(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		errors++;
	endtask

	initial begin
		errors = 0;
		mapped_reads = 0;
		results_seen = 0;
		for (int i = 0; i < BANK_BYTES; i++) begin
			rom_mem[i] = BYTE_FF;
			user_mem[i] = BYTE_FF;
			video_mem[i] = BYTE_FF;
			alt_mem[i] = BYTE_FF;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_48K;
			disk_present = 1'b0;
			result_q.delete();
		end else begin
			// results first: a request taken at this edge cannot already have its result
			if (out_valid && !out_stall) begin
				results_seen++;
				if (result_q.size() == 0) begin
					flag_error($sformatf("result %0d (%02h/%0b) with no request waiting",
						results_seen, read_data, mapped));
				end else begin
					oldest = result_q.pop_front();
					if (read_data !== oldest.data)
						flag_error($sformatf("result %0d read_data %02h, expected %02h",
							results_seen, read_data, oldest.data));
					if (mapped !== oldest.hit)
						flag_error($sformatf("result %0d mapped %0b, expected %0b",
							results_seen, mapped, oldest.hit));
					if (oldest.hit)
						mapped_reads++;
				end
			end
			if (mode_we)
				mode_q = bmad_mode_t'(mode_wdata);
			if (in_valid && !in_stall) begin
				apply_request(predicted);
				result_q.push_back(predicted);
			end
		end
	end

endmodule

/* sim/banked_memory_access_decoder_tb.sv */
`timescale 1ns / 1ps
// top of the banked memory access decoder testbench: clock, reset, stimulus and verdict
// depends on bmad_pkg, banked_memory_access_decoder and bmad_access_check

module banked_memory_access_decoder_tb;
	import bmad_pkg::*;

	// the clear sweep after reset takes most of the run, even with heavy idling, so this
	// limit leaves a wide margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_REQS  = 240;
	localparam int NUM_PHASES  = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	// request kind that the block ignores but still answers
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [1:0]  bank;
		logic [7:0]  bsel;
		logic [7:0]  vsel;
		logic        rom_off;
	} bus_req_t;

	logic       clk;
	logic       arst_n;
	logic       mode_we;
	logic [1:0] mode_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic [15:0] address;
	logic [7:0] write_data;
	logic [1:0] bank_number;
	logic [7:0] bank_select;
	logic [7:0] video_select;
	logic       disk_rom_off;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_data;
	logic       mapped;

	int   errors;
	int   pending;
	int   mapped_reads;
	int   requests_sent;
	int   cycle_count;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_req;
	logic hold_off;

	banked_memory_access_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.address      (address),
		.write_data   (write_data),
		.bank_number  (bank_number),
		.bank_select  (bank_select),
		.video_select (video_select),
		.disk_rom_off (disk_rom_off),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.mapped       (mapped)
	);

	bmad_access_check access_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.address      (address),
		.write_data   (write_data),
		.bank_number  (bank_number),
		.bank_select  (bank_select),
		.video_select (video_select),
		.disk_rom_off (disk_rom_off),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.mapped       (mapped),
		.errors       (errors),
		.pending      (pending),
		.mapped_reads (mapped_reads)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// result side: random stall at the phase's rate, forced high during the long hold
	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
	end

	// long output hold: the sender keeps offering requests, so the pipeline fills and
	// the block has to push back on its request side
	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bus_req_t bus_req(input logic [1:0] k, input logic [15:0] a,
		input logic [7:0] d, input logic [1:0] b, input logic [7:0] bs,
		input logic [7:0] vs, input logic off);
		bus_req_t r;
		r = '{k, a, d, b, bs, vs, off};
		return r;
	endfunction

	// mostly a small set of hot offsets in every 8K region, so that writes and loads
	// are read back through the mirrors; the rest covers the full address range
	function automatic bus_req_t random_request();
		bus_req_t r;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.kind = KIND_READ;
		else if (pick < 75)
			r.kind = KIND_WRITE;
		else if (pick < 95)
			r.kind = KIND_LOAD;
		else
			r.kind = KIND_UNUSED;
		if ($urandom_range(0, 99) < 75)
			r.addr = {3'($urandom_range(0, 7)), 9'd0, 4'($urandom_range(0, 15))};
		else
			r.addr = 16'($urandom);
		// the disk rom signature byte, so the disk rom comes and goes during the run
		if ($urandom_range(0, 99) < 4)
			r.addr = DISK_ROM_BASE;
		r.data = ($urandom_range(0, 9) == 0) ? BYTE_FF : 8'($urandom);
		r.bank = 2'($urandom_range(0, 3));
		r.bsel = 8'($urandom);
		r.vsel = 8'($urandom);
		r.rom_off = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// offer one request and hold it until taken; valid is never tied to stall
	task automatic send_request(input bus_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		address <= r.addr;
		write_data <= r.data;
		bank_number <= r.bank;
		bank_select <= r.bsel;
		video_select <= r.vsel;
		disk_rom_off <= r.rom_off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	// mode changes only once every outstanding result has come back
	task automatic set_machine_mode(input bmad_mode_t m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
	endtask

	initial begin
		bmad_mode_t phase_mode;

		arst_n = 1'b0;
		mode_we = 1'b0;
		mode_wdata = MODE_48K;
		in_valid = 1'b0;
		kind = KIND_READ;
		address = '0;
		write_data = '0;
		bank_number = BANK_ROM;
		bank_select = '0;
		video_select = '0;
		disk_rom_off = 1'b0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		requests_sent = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass in 48K mode, no idling; first requests wait out the clear sweep
		set_machine_mode(MODE_48K);
		// rom answers below 0x6000, cleared and then loaded
		send_request(bus_req(KIND_READ, 16'h0000, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_LOAD, 16'h0000, 8'h5A, BANK_ROM, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, 16'h0000, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b0));
		// disk rom appears once rom byte 0xE000 is not 0xFF, hidden by disk_rom_off
		send_request(bus_req(KIND_LOAD, DISK_ROM_BASE, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, DISK_ROM_BASE, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, DISK_ROM_BASE, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b1));
		// and disappears again when that byte goes back to 0xFF
		send_request(bus_req(KIND_LOAD, DISK_ROM_BASE, 8'hFF, BANK_ROM, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, 16'hFFFF, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b0));
		// 0x2000-0x3FFF mirror: write and read both land at +0x6000
		send_request(bus_req(KIND_WRITE, 16'h2000, 8'hA5, BANK_ROM, 8'h10, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, 16'h2000, 8'h00, BANK_ROM, 8'h10, 8'h00, 1'b0));
		// write to both video planes only, then read each plane and neither
		send_request(bus_req(KIND_WRITE, 16'hFFFF, 8'h3C, BANK_ROM, 8'h07, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, 16'hFFFF, 8'h00, BANK_ROM, 8'h70, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, 16'hFFFF, 8'h00, BANK_ROM, 8'h70, 8'h04, 1'b0));
		send_request(bus_req(KIND_READ, 16'hFFFF, 8'h00, BANK_ROM, 8'h70, 8'h0C, 1'b0));
		// all-ones fields: unmapped read, ignored write, unused kind
		send_request(bus_req(KIND_READ, 16'hFFFF, 8'hFF, BANK_ALT, 8'hFF, 8'hFF, 1'b1));
		send_request(bus_req(KIND_WRITE, 16'hFFFF, 8'hFF, BANK_ALT, 8'hFF, 8'hFF, 1'b1));
		send_request(bus_req(KIND_UNUSED, 16'hFFFF, 8'hFF, BANK_ALT, 8'hFF, 8'hFF, 1'b1));
		// direct loads into the other three banks
		send_request(bus_req(KIND_LOAD, 16'h0000, 8'h11, BANK_VIDEO, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_LOAD, 16'hFFFF, 8'h22, BANK_ALT, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_LOAD, 16'h0000, 8'h33, BANK_USER, 8'h00, 8'h00, 1'b0));
		// overwrite through the low mirror and read it back directly
		send_request(bus_req(KIND_WRITE, 16'h0000, 8'h00, BANK_ROM, 8'h00, 8'h00, 1'b0));
		send_request(bus_req(KIND_READ, 16'h8000, 8'h00, BANK_ROM, 8'h10, 8'h00, 1'b0));

		// random phases: every mode twice, each paired with a different idle mix
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0, 5:    phase_mode = MODE_FLAT;
				1, 4:    phase_mode = MODE_128K;
				2, 7:    phase_mode = MODE_48K;
				default: phase_mode = MODE_96K;
			endcase
			set_machine_mode(phase_mode);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 80;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 80;
				end
				default: begin
					send_idle_pct = 34;
					recv_stall_pct = 34;
				end
			endcase
			// second phase with no idling also gets the long output hold
			if (p == 4)
				hold_req = 1'b1;
			repeat (PHASE_REQS)
				send_request(random_request());
		end

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: directed pass plus %0d random phases over all four modes",
			requests_sent, NUM_PHASES);
		$display("%0d reads found a bank; idle, stall and long-hold mixes all exercised",
			mapped_reads);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* files.f */
design/bmad_pkg.sv
design/bmad_ram.sv
design/bmad_decode.sv
design/banked_memory_access_decoder.sv
sim/bmad_access_check.sv
sim/banked_memory_access_decoder_tb.sv
